// ----- sv/urxf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared word types and operation codes for the UART receive FIFO with
// idle-gap frame counting.
// ----------------------------------------------------------------------------
package urxf_pkg;

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_RX_BYTE  = 3'd0;
    localparam logic [2:0] KIND_TICK     = 3'd1;
    localparam logic [2:0] KIND_POP      = 3'd2;
    localparam logic [2:0] KIND_PEEK     = 3'd3;
    localparam logic [2:0] KIND_FRAME_CS = 3'd4;

    localparam int GAP_W = 16;
    localparam logic [GAP_W-1:0] GAP_RESET = 16'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rx_byte;
        logic [15:0] peek_offset;
    } urxf_in_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  data_out;
        logic [8:0]  fill_level;
        logic [7:0]  frame_count;
        logic        overflow;
    } urxf_out_t;

endpackage

// ----- sv/uart_rx_fifo_with_gap_framing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_fifo_with_gap_framing
// Receive byte FIFO with idle-gap frame counting.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------------
//   in      | into      | in_valid/in_stall  | urxf_in_t  (kind, byte, peek)
//   out     | out of    | out_valid/out_stall| urxf_out_t (one per in word)
//   cfg     | into      | cfg_we             | cfg_wdata = frame_gap_ticks
//
// Push, tick, frame consume and pop on empty answer from the idle state; a
// pop with data first reads the byte store read port (ST_READ). A peek first
// runs the offset reduction unit (ST_MOD), then the read. After reset a clearing
// pass zeroes every byte store entry, with in_stall high. A result that meets
// out_stall is parked in ST_HOLD with in_stall high, so the next word is
// taken only once the parked one has gone to the output register.
// ----------------------------------------------------------------------------
module uart_rx_fifo_with_gap_framing #(
    parameter int DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  urxf_pkg::urxf_in_t in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output urxf_pkg::urxf_out_t out_word,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    import urxf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] IDX_ONE  = AW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]       state_reg,  state_next;
    logic [AW-1:0]    clr_idx_reg, clr_idx_next;
    logic [AW-1:0]    head_reg,   head_next;
    logic [AW-1:0]    tail_reg,   tail_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    logic [7:0]       frames_reg, frames_next;
    logic [GAP_W-1:0] timer_reg,  timer_next;
    logic             run_reg,    run_next;
    logic             ovf_reg,    ovf_next;
    logic [GAP_W-1:0] gap_reg;
    urxf_out_t        res_reg,    res_next;
    logic             out_valid_reg;
    urxf_out_t        out_word_reg;

    // byte store
    logic [7:0]       byte_mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             mod_start;
    logic             mod_done;
    logic [AW-1:0]    mod_rem;

    logic             out_free;
    logic             out_load;
    urxf_out_t        out_data;
    logic [CW+8:0]    cnt_ext;
    logic [AW:0]      peek_sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cnt_ext   = {9'd0, cnt_next};
    assign peek_sum  = {1'b0, head_reg} + {1'b0, mod_rem};

    urxf_offset_mod #(
        .DEPTH (DEPTH)
    ) u_offset_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .offset (in_word.peek_offset),
        .done   (mod_done),
        .rem    (mod_rem)
    );

    always_comb
    begin
        logic [GAP_W-1:0] tick_val;
        urxf_out_t        res;
        urxf_out_t        rd_res;
        logic             wait_read;

        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        frames_next  = frames_reg;
        timer_next   = timer_reg;
        run_next     = run_reg;
        ovf_next     = ovf_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = tail_reg;
        mem_wdata    = in_word.rx_byte;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;
        mod_start    = 1'b0;
        out_load     = 1'b0;
        out_data     = res_reg;
        tick_val     = timer_reg + 16'd1;
        res          = '0;
        rd_res       = res_reg;
        wait_read    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = 8'd0;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_ONE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_word.kind)
                        KIND_RX_BYTE:
                        begin
                            if (cnt_reg == FULL_CNT)
                            begin
                                // dropped byte, timer holds its value
                                ovf_next = 1'b1;
                                run_next = 1'b0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_ONE;
                                cnt_next  = cnt_reg + CNT_ONE;
                                res.ok    = 1'b1;
                                if (cnt_reg + CNT_ONE == FULL_CNT)
                                begin
                                    ovf_next   = 1'b1;
                                    run_next   = 1'b0;
                                    timer_next = '0;
                                end
                                else
                                begin
                                    ovf_next = 1'b0;
                                    run_next = 1'b1;
                                    if (timer_reg == gap_reg)
                                    begin
                                        frames_next = frames_reg + 8'd1;
                                    end
                                    timer_next = '0;
                                end
                            end
                        end

                        KIND_TICK:
                        begin
                            if (run_reg)
                            begin
                                if (tick_val == gap_reg)
                                begin
                                    frames_next = frames_reg + 8'd1;
                                    run_next    = 1'b0;
                                    timer_next  = '0;
                                end
                                else
                                begin
                                    timer_next = tick_val;
                                end
                            end
                        end

                        KIND_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_ONE;
                                cnt_next   = cnt_reg - CNT_ONE;
                                res.ok     = 1'b1;
                                wait_read  = 1'b1;
                                state_next = ST_READ;
                            end
                        end

                        KIND_PEEK:
                        begin
                            mod_start  = 1'b1;
                            wait_read  = 1'b1;
                            state_next = ST_MOD;
                        end

                        KIND_FRAME_CS:
                        begin
                            if (frames_reg != 8'd0)
                            begin
                                frames_next = frames_reg - 8'd1;
                            end
                        end

                        default:
                        begin
                        end
                    endcase

                    res.fill_level  = cnt_ext[8:0];
                    res.frame_count = frames_next;
                    res.overflow    = ovf_next;

                    if (wait_read)
                    begin
                        res_next = res;
                    end
                    else if (out_free)
                    begin
                        out_load = 1'b1;
                        out_data = res;
                    end
                    else
                    begin
                        res_next   = res;
                        state_next = ST_HOLD;
                    end
                end
            end

            ST_MOD:
            begin
                if (mod_done)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (peek_sum >= DEPTH_W) ? AW'(peek_sum - DEPTH_W)
                                                       : peek_sum[AW-1:0];
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                rd_res.data_out = rd_data_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_data   = rd_res;
                    state_next = ST_IDLE;
                end
                else
                begin
                    res_next   = rd_res;
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_data   = res_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            frames_reg    <= 8'd0;
            timer_reg     <= '0;
            run_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            frames_reg  <= frames_next;
            timer_reg   <= timer_next;
            run_reg     <= run_next;
            ovf_reg     <= ovf_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (out_load)
        begin
            out_word_reg <= out_data;
        end
    end

    // one write and one registered read per cycle; the FSM never overlaps
    // a write and a read of the same entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= byte_mem[mem_raddr];
        end
    end

endmodule

// ----- sv/urxf_offset_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_offset_mod
// Reduces a 16-bit peek offset modulo DEPTH. Power-of-two depths take a
// mask and answer in the cycle after start; other depths run a restoring
// reduction, four compare/subtract steps per cycle, and raise done together
// with the final remainder.
// ----------------------------------------------------------------------------
module urxf_offset_mod #(
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [15:0]                              offset,
    output logic                                     done,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rem
);

    localparam int  AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit  POW2 = ((DEPTH & (DEPTH - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            logic          done_reg;
            logic [AW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= offset[AW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_iter
            logic [15:0] r_reg;
            logic [15:0] r_next;
            logic [1:0]  step_reg;
            logic        busy_reg;
            logic        done_reg;

            // four restoring steps per cycle, shift 15 down to 0 across the four step_reg values
            always_comb
            begin
                logic [31:0] r_work;
                logic [31:0] dv;
                logic [3:0]  shamt;
                r_work = {16'd0, r_reg};
                for (int j = 0; j < 4; j++)
                begin
                    shamt = 4'd15 - {step_reg, 2'b00} - 4'(j);
                    dv    = 32'(DEPTH) << shamt;
                    if (r_work >= dv)
                    begin
                        r_work = r_work - dv;
                    end
                end
                r_next = r_work[15:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= 2'd0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= busy_reg && (step_reg == 2'd3);
                    if (start)
                    begin
                        step_reg <= 2'd0;
                        busy_reg <= 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        step_reg <= step_reg + 2'd1;
                        if (step_reg == 2'd3)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    r_reg <= offset;
                end
                else if (busy_reg)
                begin
                    r_reg <= r_next;
                end
            end

            assign done = done_reg;
            assign rem  = r_reg[AW-1:0];
        end
    endgenerate

endmodule

// ----- sv/urxf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_checker
// Port-level checks for the receive FIFO: output word hold, reset state and
// step-to-step consistency of fill level and frame count.
// ----------------------------------------------------------------------------
module urxf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input urxf_pkg::urxf_out_t out_word
);

    import urxf_pkg::*;

    logic       out_acc;
    logic       have_prev_reg;
    logic [8:0] prev_fill_reg;
    logic [7:0] prev_fc_reg;

    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_fill_reg <= 9'd0;
            prev_fc_reg   <= 8'd0;
        end
        else if (out_acc)
        begin
            have_prev_reg <= 1'b1;
            prev_fill_reg <= out_word.fill_level;
            prev_fc_reg   <= out_word.frame_count;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    a_reset_state: assert property (@(posedge clk)
        !rst_n |-> in_stall && !out_valid)
        else $error("block not quiet in reset");

    // a word that moved no byte leaves the fill level alone
    a_fill_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && have_prev_reg && !out_word.ok |-> out_word.fill_level == prev_fill_reg)
        else $error("fill level moved without a push or pop");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && have_prev_reg && out_word.ok |->
            (out_word.fill_level == prev_fill_reg + 9'd1) ||
            (out_word.fill_level == prev_fill_reg - 9'd1))
        else $error("fill level did not move by one on a push or pop");

    a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && have_prev_reg |->
            (out_word.frame_count == prev_fc_reg) ||
            (out_word.frame_count == prev_fc_reg + 8'd1) ||
            (out_word.frame_count == prev_fc_reg - 8'd1))
        else $error("frame count jumped");

endmodule

bind uart_rx_fifo_with_gap_framing urxf_checker u_urxf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
